[rtl/core/rx_fifo_xon_xoff_flow_defines.svh]
// assertion macros shared by the receive fifo modules
// each macro takes a label, the clock, the reset and a property or condition body
`ifndef RX_FIFO_XON_XOFF_FLOW_DEFINES_SVH
`define RX_FIFO_XON_XOFF_FLOW_DEFINES_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define RFX_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("rfx assertion failed");
// condition that must never be true outside reset
`define RFX_NEVER(lbl, clk_s, rst_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) \
    else $error("rfx forbidden condition seen");
`else
`define RFX_ASSERT(lbl, clk_s, rst_s, prop)
`define RFX_NEVER(lbl, clk_s, rst_s, cond)
`endif
`endif

[rtl/core/rfx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rfx_pkg;

  // buffer geometry
  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COUNT_W = ADDR_W + 1;
  localparam int LEVEL_W = 11;

  localparam logic [ADDR_W-1:0]  LAST_ADDR   = ADDR_W'(DEPTH - 1);
  localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(DEPTH);

  // reset values of the configuration registers
  localparam logic [LEVEL_W-1:0] HIGH_LEVEL_RST = LEVEL_W'(980);
  localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST  = LEVEL_W'(44);

  // operation codes of a request
  typedef enum logic [1:0] {
    FUNC_RX    = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_FLUSH = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  // flow character to transmit
  typedef enum logic [1:0] {
    FLOW_NONE = 2'd0,
    FLOW_XOFF = 2'd1,
    FLOW_XON  = 2'd2
  } flow_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_FLOW_ENABLE = 2'd0,
    CFG_HIGH_LEVEL  = 2'd1,
    CFG_LOW_LEVEL   = 2'd2
  } cfg_index_t;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         read_byte;
    logic               read_valid;
    flow_t              flow_send;
    logic [COUNT_W-1:0] fill_count;
    logic               overrun;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic take;    // request accepted this cycle
    logic finish;  // ram data of a read is available
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mem_read;  // current request reads a byte from the ram
  } dp_status_t;

  // ring index increment
  function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    r = (a == LAST_ADDR) ? '0 : a + ADDR_W'(1);
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/rfx_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module rfx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/rfx_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "rx_fifo_xon_xoff_flow_defines.svh"
module rfx_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire rfx_pkg::dp_status_t status,
  output rfx_pkg::ctl_cmd_t        cmd
);

  rfx_pkg::state_t state;
  rfx_pkg::state_t state_next;
  logic            out_valid_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rfx_pkg::ST_IDLE: begin
        if (cmd.take && status.mem_read) begin
          state_next = rfx_pkg::ST_READ;
        end
      end
      rfx_pkg::ST_READ: begin
        state_next = rfx_pkg::ST_IDLE;
      end
      default: begin
        state_next = rfx_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs: accept when idle and the result slot is empty or frees this cycle
  always_comb begin
    in_ready   = 1'b0;
    cmd.take   = 1'b0;
    cmd.finish = 1'b0;
    case (state)
      rfx_pkg::ST_IDLE: begin
        in_ready = !out_valid || out_ready;
      end
      rfx_pkg::ST_READ: begin
        cmd.finish = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.take = in_valid && in_ready;
    // result slot occupancy
    if ((cmd.take && !status.mem_read) || cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rfx_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `RFX_ASSERT(a_read_one_cycle, clk, rst, state == rfx_pkg::ST_READ |=> state == rfx_pkg::ST_IDLE)
  `RFX_ASSERT(a_read_delivers, clk, rst, state == rfx_pkg::ST_READ |=> out_valid)
  `RFX_ASSERT(a_direct_delivers, clk, rst, cmd.take && !status.mem_read |=> out_valid)
  `RFX_NEVER(a_no_overwrite, clk, rst, cmd.take && out_valid && !out_ready)

endmodule
`default_nettype wire

[rtl/core/rfx_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "rx_fifo_xon_xoff_flow_defines.svh"
module rfx_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire rfx_pkg::in_item_t               in_data,
  output rfx_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_valid,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [rfx_pkg::LEVEL_W-1:0]     cfg_data,
  input  wire rfx_pkg::ctl_cmd_t               cmd,
  output rfx_pkg::dp_status_t                  status
);

  // configuration
  logic                        flow_enable;
  logic [rfx_pkg::LEVEL_W-1:0] high_level;
  logic [rfx_pkg::LEVEL_W-1:0] low_level;

  // buffer state
  logic [rfx_pkg::ADDR_W-1:0]  write_index;
  logic [rfx_pkg::ADDR_W-1:0]  read_index;
  logic [rfx_pkg::COUNT_W-1:0] held_count;
  logic                        xoff_pending;

  logic [rfx_pkg::ADDR_W-1:0]  write_index_next;
  logic [rfx_pkg::ADDR_W-1:0]  read_index_next;
  logic [rfx_pkg::COUNT_W-1:0] held_count_next;
  logic                        xoff_pending_next;

  rfx_pkg::flow_t flow;
  logic           rvalid;
  logic           ovr;
  logic           ram_we;
  logic [7:0]     ram_rdata;

  // per-request update of the ring and flow state
  always_comb begin
    write_index_next  = write_index;
    read_index_next   = read_index;
    held_count_next   = held_count;
    xoff_pending_next = xoff_pending;
    flow              = rfx_pkg::FLOW_NONE;
    rvalid            = 1'b0;
    ovr               = 1'b0;
    ram_we            = 1'b0;
    case (in_data.func)
      rfx_pkg::FUNC_RX: begin
        if (held_count == rfx_pkg::DEPTH_COUNT) begin
          ovr = 1'b1;
        end else begin
          ram_we           = 1'b1;
          write_index_next = rfx_pkg::next_addr(write_index);
          held_count_next  = held_count + rfx_pkg::COUNT_W'(1);
        end
        // xoff test applies to the count after the byte, dropped or not
        if (flow_enable && (held_count_next > high_level) && !xoff_pending) begin
          flow              = rfx_pkg::FLOW_XOFF;
          xoff_pending_next = 1'b1;
        end
      end
      rfx_pkg::FUNC_READ: begin
        if ((held_count < low_level) && xoff_pending) begin
          flow              = rfx_pkg::FLOW_XON;
          xoff_pending_next = 1'b0;
        end
        if (held_count != '0) begin
          rvalid          = 1'b1;
          read_index_next = rfx_pkg::next_addr(read_index);
          held_count_next = held_count - rfx_pkg::COUNT_W'(1);
        end
      end
      rfx_pkg::FUNC_FLUSH: begin
        if (xoff_pending) begin
          flow              = rfx_pkg::FLOW_XON;
          xoff_pending_next = 1'b0;
        end
        write_index_next = '0;
        read_index_next  = '0;
        held_count_next  = '0;
      end
      default: begin
        flow = rfx_pkg::FLOW_NONE;
      end
    endcase
  end

  assign status.mem_read = rvalid;

  // byte store, read address taken before the index advances
  rfx_ram #(
    .WIDTH (8),
    .DEPTH (rfx_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.take && ram_we),
    .waddr (write_index),
    .wdata (in_data.rx_byte),
    .re    (cmd.take),
    .raddr (read_index),
    .rdata (ram_rdata)
  );

  // configuration registers and buffer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      flow_enable  <= 1'b0;
      high_level   <= rfx_pkg::HIGH_LEVEL_RST;
      low_level    <= rfx_pkg::LOW_LEVEL_RST;
      write_index  <= '0;
      read_index   <= '0;
      held_count   <= '0;
      xoff_pending <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rfx_pkg::CFG_FLOW_ENABLE: flow_enable <= cfg_data[0];
          rfx_pkg::CFG_HIGH_LEVEL:  high_level  <= cfg_data;
          rfx_pkg::CFG_LOW_LEVEL:   low_level   <= cfg_data;
          default: begin
            flow_enable <= flow_enable;
          end
        endcase
      end
      if (cmd.take) begin
        write_index  <= write_index_next;
        read_index   <= read_index_next;
        held_count   <= held_count_next;
        xoff_pending <= xoff_pending_next;
      end
    end
  end

  // result register, read byte filled from the ram read port in the read state on a ram read
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      out_data.read_byte  <= 8'd0;
      out_data.read_valid <= rvalid;
      out_data.flow_send  <= flow;
      out_data.fill_count <= held_count_next;
      out_data.overrun    <= ovr;
    end
    if (cmd.finish) begin
      out_data.read_byte <= ram_rdata;
    end
  end

  `RFX_ASSERT(a_count_bound, clk, rst, held_count <= rfx_pkg::DEPTH_COUNT)
  `RFX_ASSERT(a_flush_empties, clk, rst, cmd.take && in_data.func == rfx_pkg::FUNC_FLUSH
              |=> held_count == '0 && !xoff_pending)

endmodule
`default_nettype wire

[rtl/core/rx_fifo_xon_xoff_flow.sv]
// Receive byte buffer with software XON/XOFF flow control.
// Request channel (in_valid/in_ready/in_data): func selects received byte,
// read, flush or no operation; rx_byte is the line byte for a receive.
// Result channel (out_valid/out_ready/out_data): one result per request,
// with the read byte, flow character to send, fill count and overrun flag.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): flow enable,
// high level and low level; always ready; the user must write it only while
// the block is idle, which the block does not enforce. Receive, flush, no-op
// and empty reads register their result at acceptance; a read of a stored
// byte first passes the registered read port of the 1024 x 8 ram.
// One request per cycle while results drain; a read that returns data holds
// off the next request while the two-state controller is in its read state.
// Reset clears indices, fill count, pending XOFF and sets default levels;
// the ram needs no clearing pass. A stalled result holds in the output
// register; a new request is taken in the cycle the old result leaves.
`timescale 1ns / 1ps
`default_nettype none
module rx_fifo_xon_xoff_flow (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire rfx_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output rfx_pkg::out_item_t               out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [rfx_pkg::LEVEL_W-1:0] cfg_data
);

  rfx_pkg::ctl_cmd_t   cmd;
  rfx_pkg::dp_status_t status;

  // configuration writes never stall
  assign cfg_ready = 1'b1;

  // control
  rfx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // buffer, flow state and result register
  rfx_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire
